@@ rtl/rv32s_pkg.sv @@
// Shared types and constants for the RV32 subset execute block.
// Used by the multiply/divide unit and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rv32s_pkg;

   // Major opcodes
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_LUI    = 7'h37;

   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;

   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

   // Ecall service numbers in a0
   localparam logic [31:0] SVC_PRINT_INT  = 32'd1;
   localparam logic [31:0] SVC_PRINT_STR  = 32'd4;
   localparam logic [31:0] SVC_EXIT       = 32'd10;
   localparam logic [31:0] SVC_PRINT_CHAR = 32'd11;

   // Result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_EXIT    = 3'd2;
   localparam logic [2:0] ST_ILLEGAL = 3'd3;
   localparam logic [2:0] ST_HALTED  = 3'd4;

   // Ecall request kinds
   localparam logic [1:0] EK_NONE  = 2'd0;
   localparam logic [1:0] EK_INT   = 2'd1;
   localparam logic [1:0] EK_STR   = 2'd2;
   localparam logic [1:0] EK_CHAR  = 2'd3;

   typedef enum logic [1:0] {
      MDU_MUL  = 2'd0,
      MDU_MULH = 2'd1,
      MDU_DIV  = 2'd2,
      MDU_REM  = 2'd3
   } mdu_op_type;

   typedef struct packed {
      logic       start;
      mdu_op_type op;
   } mdu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mdu_stat_type;

endpackage

`default_nettype wire

@@ rtl/rv32_subset_instruction_execute.sv @@
// Top level of the RV32 subset execute block: sequencer, decode and memories.
// Depends on rv32s_pkg, rv32s_ram and rv32s_mdu.
//
// Usage: the request channel (req_valid, req_stall, req_instruction_word) carries
// one instruction word fetched at the current program counter per transfer. The
// response channel (rsp_valid, rsp_stall, rsp_*) returns exactly one result per
// instruction: the next PC, a status, and any ecall request with its a1 value.
// The block works on one instruction at a time and holds req_stall high until
// it can take the next one. Multiply, divide and remainder run as 32 one-bit
// steps in the shared multiply/divide unit. Loads and stores first reduce the
// address modulo MEM_BYTES, then bytes move one at a time through the single
// data memory port. Once halted, each instruction is answered directly with
// the halted status. The next request is taken in the cycle after the response
// register loads. After reset the register file reads as zero through
// per-register valid bits, and the data memory is cleared by a pass over all
// MEM_BYTES addresses, during which no request is taken. While the receiver
// stalls the response holds steady, and a finished instruction waits for it.
`timescale 1ns / 1ps
`default_nettype none

module rv32_subset_instruction_execute #(
   parameter int MEM_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instruction_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_pc,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_ecall_kind,
   output logic [31:0]      rsp_ecall_value
);

   localparam int AW   = $clog2(MEM_BYTES);
   // Largest shift of the modulus used to reduce any 32-bit address.
   localparam int KTOP = 32 - AW;

   typedef enum logic [11:0] {
      S_CLEAR = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_RS1   = 12'b0000_0000_0100,
      S_RS2   = 12'b0000_0000_1000,
      S_EXEC  = 12'b0000_0001_0000,
      S_MDU   = 12'b0000_0010_0000,
      S_MOD   = 12'b0000_0100_0000,
      S_LOAD  = 12'b0000_1000_0000,
      S_LWAIT = 12'b0001_0000_0000,
      S_STORE = 12'b0010_0000_0000,
      S_WB    = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [31:0]     instr_ff, instr_in;
   logic [31:0]     pc_ff, pc_in;
   logic            halted_ff, halted_in;
   logic [31:0]     a_ff, a_in;
   logic [31:0]     res_ff, res_in;
   logic [31:0]     npc_ff, npc_in;
   logic [2:0]      status_ff, status_in;
   logic [1:0]      kind_ff, kind_in;
   logic [31:0]     val_ff, val_in;
   logic [31:0]     mod_ff, mod_in;
   logic [4:0]      k_ff, k_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [1:0]      j_ff, j_in;
   logic [31:0]     lv_ff, lv_in;
   logic [31:0]     sv_ff, sv_in;
   logic [31:0]     rf_valid_ff, rf_valid_in;
   logic            rfv_rd_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_pc_ff;
   logic [2:0]      rsp_status_ff;
   logic [1:0]      rsp_kind_ff;
   logic [31:0]     rsp_val_ff;
   logic            out_load;

   // Instruction fields
   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [4:0]  rd, rs1_sel, rs2_sel;
   logic [31:0] imm_i, imm_s, imm_b, imm_j;

   // Register file and data memory ports
   logic [4:0]    rf_raddr;
   logic [31:0]   rf_q, rd_val;
   logic          rf_we;
   logic          dm_we;
   logic [7:0]    dm_wdata, dm_q;

   // Multiply/divide unit
   rv32s_pkg::mdu_req_type  mdu_req;
   rv32s_pkg::mdu_stat_type mdu_stat;
   logic [31:0]             mdu_res;

   // Combinational ALU decode for the execute step
   logic                  alu_ok, alu_mdu;
   logic [31:0]           alu_res;
   rv32s_pkg::mdu_op_type alu_mop;

   logic [32:0] mshift;
   logic [31:0] addr;
   logic [1:0]  nlast;
   logic [31:0] lv_next;

   assign opc     = instr_ff[6:0];
   assign rd      = instr_ff[11:7];
   assign f3      = instr_ff[14:12];
   assign f7      = instr_ff[31:25];
   // An ecall reads a0 and a1 instead of the encoded source registers.
   assign rs1_sel = (opc == rv32s_pkg::OPC_SYSTEM) ? 5'd10 : instr_ff[19:15];
   assign rs2_sel = (opc == rv32s_pkg::OPC_SYSTEM) ? 5'd11 : instr_ff[24:20];
   assign imm_i   = {{20{instr_ff[31]}}, instr_ff[31:20]};
   assign imm_s   = {{20{instr_ff[31]}}, instr_ff[31:25], instr_ff[11:7]};
   assign imm_b   = {{19{instr_ff[31]}}, instr_ff[31], instr_ff[7], instr_ff[30:25],
                     instr_ff[11:8], 1'b0};
   assign imm_j   = {{11{instr_ff[31]}}, instr_ff[31], instr_ff[19:12], instr_ff[20],
                     instr_ff[30:21], 1'b0};

   assign rf_raddr = (state_ff == S_RS1) ? rs1_sel : rs2_sel;
   // A register never written since reset reads as zero; x0 is never written.
   assign rd_val   = rfv_rd_ff ? rf_q : 32'd0;
   assign rf_we    = (state_ff == S_WB) && (rd != 5'd0);

   assign dm_we    = (state_ff == S_CLEAR) || (state_ff == S_STORE);
   assign dm_wdata = (state_ff == S_STORE) ? sv_ff[7:0] : 8'd0;

   assign addr    = a_ff + ((opc == rv32s_pkg::OPC_STORE) ? imm_s : imm_i);
   assign mshift  = 33'(MEM_BYTES) << k_ff;
   assign nlast   = {f3[1], f3[1] | f3[0]};
   assign lv_next = {dm_q, lv_ff[31:8]};

   assign req_stall = (state_ff != S_IDLE);
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // ALU for register and immediate forms; rs2 data arrives from the RAM now.
   always_comb begin
      logic [31:0] opb;
      logic [4:0]  sh;
      alu_ok  = 1'b1;
      alu_mdu = 1'b0;
      alu_res = 32'd0;
      alu_mop = rv32s_pkg::MDU_MUL;
      opb     = (opc == rv32s_pkg::OPC_OP) ? rd_val : imm_i;
      sh      = opb[4:0];
      if (opc == rv32s_pkg::OPC_OP) begin
         case ({f3, f7})
            {3'd0, rv32s_pkg::F7_BASE}:   alu_res = a_ff + opb;
            {3'd0, rv32s_pkg::F7_ALT}:    alu_res = a_ff - opb;
            {3'd1, rv32s_pkg::F7_BASE}:   alu_res = a_ff << sh;
            {3'd2, rv32s_pkg::F7_BASE}:   alu_res = {31'd0, $signed(a_ff) < $signed(opb)};
            {3'd4, rv32s_pkg::F7_BASE}:   alu_res = a_ff ^ opb;
            {3'd5, rv32s_pkg::F7_BASE}:   alu_res = a_ff >> sh;
            {3'd5, rv32s_pkg::F7_ALT}:    alu_res = 32'($signed(a_ff) >>> sh);
            {3'd6, rv32s_pkg::F7_BASE}:   alu_res = a_ff | opb;
            {3'd7, rv32s_pkg::F7_BASE}:   alu_res = a_ff & opb;
            {3'd0, rv32s_pkg::F7_MULDIV}: begin
               alu_mdu = 1'b1;
               alu_mop = rv32s_pkg::MDU_MUL;
            end
            {3'd1, rv32s_pkg::F7_MULDIV}: begin
               alu_mdu = 1'b1;
               alu_mop = rv32s_pkg::MDU_MULH;
            end
            {3'd4, rv32s_pkg::F7_MULDIV}: begin
               alu_mdu = 1'b1;
               alu_mop = rv32s_pkg::MDU_DIV;
            end
            {3'd6, rv32s_pkg::F7_MULDIV}: begin
               alu_mdu = 1'b1;
               alu_mop = rv32s_pkg::MDU_REM;
            end
            default: alu_ok = 1'b0;
         endcase
      end else begin
         case (f3)
            3'd0: alu_res = a_ff + opb;
            3'd1: begin
               alu_res = a_ff << sh;
               alu_ok  = (f7 == rv32s_pkg::F7_BASE);
            end
            3'd2: alu_res = {31'd0, $signed(a_ff) < $signed(opb)};
            3'd4: alu_res = a_ff ^ opb;
            3'd5: begin
               if (f7 == rv32s_pkg::F7_BASE) begin
                  alu_res = a_ff >> sh;
               end else if (f7 == rv32s_pkg::F7_ALT) begin
                  alu_res = 32'($signed(a_ff) >>> sh);
               end else begin
                  alu_ok = 1'b0;
               end
            end
            3'd6: alu_res = a_ff | opb;
            3'd7: alu_res = a_ff & opb;
            default: alu_ok = 1'b0;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      logic bad;
      bad         = 1'b0;
      state_in    = state_ff;
      instr_in    = instr_ff;
      pc_in       = pc_ff;
      halted_in   = halted_ff;
      a_in        = a_ff;
      res_in      = res_ff;
      npc_in      = npc_ff;
      status_in   = status_ff;
      kind_in     = kind_ff;
      val_in      = val_ff;
      mod_in      = mod_ff;
      k_in        = k_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      lv_in       = lv_ff;
      sv_in       = sv_ff;
      rf_valid_in = rf_valid_ff;
      mdu_req     = '{start: 1'b0, op: alu_mop};

      case (state_ff)
         S_CLEAR: begin
            if (idx_ff == AW'(MEM_BYTES - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               instr_in  = req_instruction_word;
               status_in = rv32s_pkg::ST_OK;
               kind_in   = rv32s_pkg::EK_NONE;
               val_in    = 32'd0;
               npc_in    = pc_ff;
               if (halted_ff) begin
                  status_in = rv32s_pkg::ST_HALTED;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_RS1;
               end
            end
         end
         S_RS1: state_in = S_RS2;
         S_RS2: begin
            a_in     = rd_val;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            npc_in = pc_ff + 32'd4;
            case (opc)
               rv32s_pkg::OPC_OP, rv32s_pkg::OPC_OP_IMM: begin
                  if (!alu_ok) begin
                     bad = 1'b1;
                  end else if (alu_mdu) begin
                     mdu_req.start = 1'b1;
                     state_in      = S_MDU;
                  end else begin
                     res_in   = alu_res;
                     state_in = S_WB;
                  end
               end
               rv32s_pkg::OPC_LOAD, rv32s_pkg::OPC_STORE: begin
                  if (f3 > 3'd2 || (opc == rv32s_pkg::OPC_LOAD && f3 == 3'd3)) begin
                     bad = 1'b1;
                  end else begin
                     mod_in   = addr;
                     k_in     = 5'(KTOP);
                     sv_in    = rd_val;
                     state_in = S_MOD;
                  end
               end
               rv32s_pkg::OPC_BRANCH: begin
                  if (f3 == 3'd0 || f3 == 3'd1) begin
                     if ((a_ff == rd_val) != f3[0]) begin
                        npc_in = pc_ff + imm_b;
                     end
                     state_in = S_DONE;
                  end else begin
                     bad = 1'b1;
                  end
               end
               rv32s_pkg::OPC_JAL: begin
                  res_in   = pc_ff + 32'd4;
                  npc_in   = pc_ff + imm_j;
                  state_in = S_WB;
               end
               rv32s_pkg::OPC_LUI: begin
                  res_in   = {instr_ff[31:12], 12'd0};
                  state_in = S_WB;
               end
               rv32s_pkg::OPC_SYSTEM: begin
                  if (instr_ff != rv32s_pkg::ECALL_WORD) begin
                     bad = 1'b1;
                  end else begin
                     state_in = S_DONE;
                     if (a_ff == rv32s_pkg::SVC_PRINT_INT) begin
                        kind_in = rv32s_pkg::EK_INT;
                        val_in  = rd_val;
                     end else if (a_ff == rv32s_pkg::SVC_PRINT_STR) begin
                        kind_in = rv32s_pkg::EK_STR;
                        val_in  = rd_val;
                     end else if (a_ff == rv32s_pkg::SVC_PRINT_CHAR) begin
                        kind_in = rv32s_pkg::EK_CHAR;
                        val_in  = rd_val;
                     end else begin
                        status_in = (a_ff == rv32s_pkg::SVC_EXIT) ?
                                    rv32s_pkg::ST_EXIT : rv32s_pkg::ST_ILLEGAL;
                        halted_in = 1'b1;
                        npc_in    = pc_ff;
                     end
                  end
               end
               default: bad = 1'b1;
            endcase
            if (bad) begin
               status_in = rv32s_pkg::ST_INVALID;
               halted_in = 1'b1;
               npc_in    = pc_ff;
               state_in  = S_DONE;
            end
         end
         S_MDU: begin
            if (mdu_stat.done) begin
               res_in   = mdu_res;
               state_in = S_WB;
            end
         end
         S_MOD: begin
            // Restoring reduction: subtract MEM_BYTES shifted left by k if it fits.
            if ({1'b0, mod_ff} >= mshift) begin
               mod_in = mod_ff - mshift[31:0];
            end
            if (k_ff == 5'd0) begin
               idx_in   = mod_in[AW-1:0];
               j_in     = 2'd0;
               state_in = (opc == rv32s_pkg::OPC_LOAD) ? S_LOAD : S_STORE;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         S_LOAD: state_in = S_LWAIT;
         S_LWAIT: begin
            lv_in  = lv_next;
            idx_in = (idx_ff == AW'(MEM_BYTES - 1)) ? '0 : idx_ff + AW'(1);
            j_in   = j_ff + 2'd1;
            if (j_ff == nlast) begin
               case (f3[1:0])
                  2'd0:    res_in = {{24{lv_next[31]}}, lv_next[31:24]};
                  2'd1:    res_in = {{16{lv_next[31]}}, lv_next[31:16]};
                  default: res_in = lv_next;
               endcase
               state_in = S_WB;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_STORE: begin
            sv_in  = {8'd0, sv_ff[31:8]};
            idx_in = (idx_ff == AW'(MEM_BYTES - 1)) ? '0 : idx_ff + AW'(1);
            j_in   = j_ff + 2'd1;
            if (j_ff == nlast) begin
               state_in = S_DONE;
            end
         end
         S_WB: begin
            if (rd != 5'd0) begin
               rf_valid_in[rd] = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               pc_in    = npc_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         pc_ff        <= 32'd0;
         halted_ff    <= 1'b0;
         rf_valid_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      instr_ff  <= instr_in;
      a_ff      <= a_in;
      res_ff    <= res_in;
      npc_ff    <= npc_in;
      status_ff <= status_in;
      kind_ff   <= kind_in;
      val_ff    <= val_in;
      mod_ff    <= mod_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      lv_ff     <= lv_in;
      sv_ff     <= sv_in;
      rfv_rd_ff <= rf_valid_ff[rf_raddr];
      if (out_load) begin
         rsp_pc_ff     <= npc_ff;
         rsp_status_ff <= status_ff;
         rsp_kind_ff   <= kind_ff;
         rsp_val_ff    <= val_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_ecall_kind  = rsp_kind_ff;
   assign rsp_ecall_value = rsp_val_ff;

   rv32s_ram #(
      .WIDTH(32),
      .DEPTH(32)
   ) u_regfile (
      .clock  (clock),
      .wr_en  (rf_we),
      .wr_addr(rd),
      .wr_data(res_ff),
      .rd_addr(rf_raddr),
      .rd_data(rf_q)
   );

   rv32s_ram #(
      .WIDTH(8),
      .DEPTH(MEM_BYTES)
   ) u_dmem (
      .clock  (clock),
      .wr_en  (dm_we),
      .wr_addr(idx_ff),
      .wr_data(dm_wdata),
      .rd_addr(idx_ff),
      .rd_data(dm_q)
   );

   rv32s_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .opa   (a_ff),
      .opb   (rd_val),
      .stat  (mdu_stat),
      .result(mdu_res)
   );

   // A response becomes valid only as the sequencer retires an instruction.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside retirement");

   // Once halted, only reset leaves the halted state.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag dropped without reset");

   // The multiply/divide unit runs only while the sequencer waits for it.
   a_mdu_owned: assert property (@(posedge clock) disable iff (reset)
      mdu_stat.busy |-> (state_ff == S_MDU))
      else $error("multiply/divide unit busy outside its wait state");

endmodule

`default_nettype wire

@@ rtl/rv32s_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the register file and the data memory.
`timescale 1ns / 1ps
`default_nettype none

module rv32s_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/rv32s_mdu.sv @@
// Iterative multiply/divide unit: one shared 34-bit adder, one bit per cycle.
// Depends on rv32s_pkg for the operation codes and control structs.
`timescale 1ns / 1ps
`default_nettype none

module rv32s_mdu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rv32s_pkg::mdu_req_type req,
   input  wire logic [31:0]           opa,
   input  wire logic [31:0]           opb,
   output rv32s_pkg::mdu_stat_type    stat,
   output logic      [31:0]           result
);

   logic                  run_ff, run_in;
   logic                  fin_ff, fin_in;
   logic [4:0]            cnt_ff, cnt_in;
   rv32s_pkg::mdu_op_type op_ff, op_in;
   logic [31:0]           hi_ff, hi_in;
   logic [31:0]           lo_ff, lo_in;
   logic [31:0]           y_ff, y_in;
   logic [31:0]           a0_ff, a0_in;
   logic                  neg_ff, neg_in;
   logic                  dz_ff, dz_in;

   logic        is_div;
   logic [33:0] x34, y34, sum34;
   logic [63:0] pneg;
   logic [31:0] ua, ub;

   assign is_div = (op_ff == rv32s_pkg::MDU_DIV) || (op_ff == rv32s_pkg::MDU_REM);
   assign x34 = is_div ? {1'b0, hi_ff, lo_ff[31]} : {2'b00, hi_ff};
   assign y34 = (is_div || lo_ff[0]) ? {2'b00, y_ff} : 34'd0;
   // The one adder: subtracts for division, adds for multiplication.
   assign sum34 = x34 + (is_div ? ~y34 : y34) + {33'd0, is_div};
   assign pneg = 64'd0 - {hi_ff, lo_ff};
   assign ua = opa[31] ? (32'd0 - opa) : opa;
   assign ub = opb[31] ? (32'd0 - opb) : opb;

   always_comb begin
      run_in = run_ff;
      fin_in = 1'b0;
      cnt_in = cnt_ff;
      op_in  = op_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      y_in   = y_ff;
      a0_in  = a0_ff;
      neg_in = neg_ff;
      dz_in  = dz_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = 5'd0;
         op_in  = req.op;
         hi_in  = 32'd0;
         lo_in  = ua;
         y_in   = ub;
         a0_in  = opa;
         dz_in  = (opb == 32'd0);
         neg_in = (req.op == rv32s_pkg::MDU_REM) ? opa[31] : (opa[31] ^ opb[31]);
      end else if (run_ff) begin
         if (is_div) begin
            if (!sum34[33]) begin
               hi_in = sum34[31:0];
               lo_in = {lo_ff[30:0], 1'b1};
            end else begin
               hi_in = x34[31:0];
               lo_in = {lo_ff[30:0], 1'b0};
            end
         end else begin
            hi_in = sum34[32:1];
            lo_in = {sum34[0], lo_ff[31:1]};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_comb begin
      case (op_ff)
         rv32s_pkg::MDU_MUL:  result = neg_ff ? pneg[31:0] : lo_ff;
         rv32s_pkg::MDU_MULH: result = neg_ff ? pneg[63:32] : hi_ff;
         rv32s_pkg::MDU_DIV:  result = dz_ff ? 32'hFFFF_FFFF :
                                       (neg_ff ? (32'd0 - lo_ff) : lo_ff);
         rv32s_pkg::MDU_REM:  result = dz_ff ? a0_ff :
                                       (neg_ff ? (32'd0 - hi_ff) : hi_ff);
         default:             result = lo_ff;
      endcase
   end

   assign stat.busy = run_ff | fin_ff;
   assign stat.done = fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      y_ff   <= y_in;
      a0_ff  <= a0_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
   end

endmodule

`default_nettype wire
